// ===== rtl/core/rwtc_pkg.sv =====
// Shared types, constants and the cosine table function for the wall texture column mapper.
`timescale 1ns / 1ps

package rwtc_pkg;

    localparam int COS_TABLE_DEPTH  = 1024;
    localparam int COS_IDX_W        = $clog2(COS_TABLE_DEPTH);
    localparam int MAX_TEXTURE_SIZE = 1024;
    localparam int MAX_SCREEN_ROWS  = 1024;
    localparam int DIST_EPSILON     = 7;
    localparam int DIV_W            = 40;
    localparam int DSR_W            = 25;
    localparam int IN_W             = 144;
    localparam int OUT_W            = 88;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_W            = 11;
    localparam logic [19:0] HEIGHT_MAX = 20'hFFFFF;

    localparam logic OP_SETUP     = 1'b0;
    localparam logic OP_ROW       = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_HEIGHT,
        CFG_TEXTURE_WIDTH,
        CFG_TEXTURE_HEIGHT
    } cfg_idx_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic mult;
        logic div_start;
        logic finish;
        logic load_out;
    } rwtc_cmd_t;

    typedef struct packed {
        logic div_done;
    } rwtc_status_t;

    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // Floor division of a series term by its index; the terms past the second stay
    // below 2^31, so the reciprocal products are exact.
    function automatic longint unsigned div_small(input longint unsigned t, input int n);
        longint unsigned r;
        case (n)
            2:       r = t >> 1;
            3:       r = (t * 64'd2863311531) >> 33;
            4:       r = t >> 2;
            5:       r = (t * 64'd3435973837) >> 34;
            6:       r = (t * 64'd2863311531) >> 34;
            7:       r = (t * 64'd2454267027) >> 34;
            8:       r = t >> 3;
            9:       r = (t * 64'd3817748708) >> 35;
            10:      r = (t * 64'd3435973837) >> 35;
            11:      r = (t * 64'd3123612579) >> 35;
            12:      r = (t * 64'd2863311531) >> 35;
            13:      r = (t * 64'd2643056798) >> 35;
            default: r = t;
        endcase
        return r;
    endfunction

    // Cosine of one table entry in Q2.14, from a Taylor series in Q30 fixed point.
    function automatic logic signed [15:0] cos_entry(input int unsigned k);
        longint unsigned ph;
        longint unsigned x;
        longint unsigned term;
        longint unsigned quad;
        longint          c;
        longint          s;
        longint          v;
        longint          mag;
        ph   = (longint'(k) << 32) / COS_TABLE_DEPTH;
        quad = (ph >> 30) & 64'd3;
        x    = ((ph & 64'h3FFF_FFFF) * 64'd1686629713) >> 30;
        term = 64'd1 << 30;
        c    = 0;
        s    = 0;
        for (int n = 0; n <= 13; n++) begin
            if (n > 0)
                term = div_small((term * x) >> 30, n);
            if ((n % 2) == 0)
                c = (((n / 2) % 2) == 1) ? c - longint'(term) : c + longint'(term);
            else
                s = ((((n - 1) / 2) % 2) == 1) ? s - longint'(term) : s + longint'(term);
        end
        if (quad == 0)
            v = c;
        else if (quad == 1)
            v = -s;
        else if (quad == 2)
            v = -c;
        else
            v = s;
        mag = (v < 0) ? -v : v;
        mag = (mag + 32768) >>> 16;
        return 16'((v < 0) ? -mag : mag);
    endfunction

endpackage

// ===== rtl/core/rwtc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rwtc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rwtc_pkg::DIV_W-1:0]  dividend,
    input  logic [rwtc_pkg::DSR_W-1:0]  divisor,
    output logic                        done,
    output logic [rwtc_pkg::DIV_W-1:0]  quotient
);
    import rwtc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] acc_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W:0]   rem_sh;
    logic             fits;

    assign rem_sh   = {rem_reg, acc_reg[DIV_W-1]};
    assign fits     = rem_sh >= {1'b0, divisor};
    assign done     = done_reg;
    assign quotient = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DSR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DSR_W-1:0];
            acc_reg <= {acc_reg[DIV_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/core/rwtc_ctrl.sv =====
// Sequencer that steps one item through the datapath and owns the output valid.
`timescale 1ns / 1ps

module rwtc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  rwtc_pkg::rwtc_status_t  status,
    output rwtc_pkg::rwtc_cmd_t     cmd
);
    import rwtc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MULT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd           = '0;
        cmd.load_in   = (state_reg == ST_IDLE) && in_valid;
        cmd.prep      = (state_reg == ST_PREP);
        cmd.mult      = (state_reg == ST_MULT);
        cmd.div_start = (state_reg == ST_DIV_GO);
        cmd.finish    = (state_reg == ST_FIN);
        cmd.load_out  = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_PREP;
                end
                ST_PREP:     state_reg <= ST_MULT;
                ST_MULT:     state_reg <= ST_DIV_GO;
                ST_DIV_GO:   state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT:
                begin
                    if (status.div_done)
                        state_reg <= ST_FIN;
                end
                ST_FIN:      state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/rwtc_datapath.sv =====
// Datapath: configuration, column state, multipliers, cosine table and the shared divider.
`timescale 1ns / 1ps

module rwtc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rwtc_pkg::rwtc_cmd_t             cmd,
    output rwtc_pkg::rwtc_status_t          status,
    input  logic [rwtc_pkg::IN_W-1:0]       in_data,
    input  logic                            in_op,
    output logic [rwtc_pkg::OUT_W-1:0]      out_data,
    output logic                            out_kind,
    input  logic                            cfg_we,
    input  logic [rwtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwtc_pkg::CFG_W-1:0]      cfg_data
);
    import rwtc_pkg::*;

    // Configuration and column state.
    logic [10:0] sh_reg, tw_reg, th_reg;
    logic        column_ready_reg;
    logic [1:0]  tex_reg;
    logic [9:0]  tex_x_reg;
    logic [19:0] line_height_reg;
    logic [10:0] span_start_reg, span_end_reg, column_reg;

    // Item and intermediate registers.
    logic               op_reg, hit_reg, sxp_reg, syp_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg;
    logic [23:0]        px_reg, py_reg, perp_reg;
    logic [11:0]        ang_reg;
    logic [10:0]        col_in_reg;
    logic [9:0]         row_reg;
    logic signed [15:0] cos_reg;
    logic signed [40:0] prod_reg, cp_reg;
    logic [26:0]        txp_reg;
    logic signed [29:0] d_reg;
    logic [DIV_W-1:0]   num_reg;
    logic               d_neg_reg;
    logic [OUT_W-1:0]   res_reg, out_reg;
    logic               res_kind_reg, out_kind_reg;

    logic [10:0] h_eff, w_eff, th_eff;
    logic signed [15:0] cos_rom [COS_TABLE_DEPTH];

    logic signed [15:0] d_sel;
    logic [23:0]        base_sel;
    logic [15:0]        frac;
    logic [28:0]        d_abs;
    logic [DIV_W-1:0]   dvd;
    logic [DSR_W-1:0]   dsr;
    logic               div_done;
    logic [DIV_W-1:0]   q;

    logic [19:0] hh;
    logic [9:0]  tx_raw, tx_fin;
    logic [1:0]  tex_fin;
    logic [10:0] st_fin, en_fin;
    logic [19:0] en_sum;
    logic [31:0] q_hi;
    logic        in_span, pv;
    logic [9:0]  ty;
    logic [20:0] texel_full;
    logic [19:0] texel;

    assign h_eff  = clamp_cfg(sh_reg, 11'(MAX_SCREEN_ROWS));
    assign w_eff  = clamp_cfg(tw_reg, 11'(MAX_TEXTURE_SIZE));
    assign th_eff = clamp_cfg(th_reg, 11'(MAX_TEXTURE_SIZE));

    for (genvar g = 0; g < COS_TABLE_DEPTH; g++)
    begin : g_cos
        assign cos_rom[g] = cos_entry(g);
    end

    assign d_sel    = hit_reg ? dir_x_reg : dir_y_reg;
    assign base_sel = hit_reg ? px_reg : py_reg;
    // Arithmetic shift floors the scaled product also for negative directions.
    assign frac     = base_sel[15:0] + 16'(prod_reg >>> 14);
    assign d_abs    = d_reg[29] ? 29'(-d_reg) : d_reg[28:0];

    assign dvd = op_reg ? num_reg : DIV_W'({h_eff, 16'b0});
    assign dsr = op_reg ? DSR_W'(line_height_reg)
                        : DSR_W'(cp_reg[38:14] + 25'(DIST_EPSILON));

    rwtc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dsr),
        .done     (div_done),
        .quotient (q)
    );

    assign status.div_done = div_done;

    // Column setup results.
    always_comb
    begin
        if (cp_reg < 0)
            hh = '0;
        else if (q[DIV_W-1:20] != '0)
            hh = HEIGHT_MAX;
        else
            hh = q[19:0];
        tx_raw = txp_reg[25:16];
        if ((!hit_reg && dir_x_reg > 0) || (hit_reg && dir_y_reg < 0))
            tx_fin = 10'(w_eff - 11'd1 - {1'b0, tx_raw});
        else
            tx_fin = tx_raw;
        tex_fin = hit_reg ? (syp_reg ? 2'd0 : 2'd1) : (sxp_reg ? 2'd3 : 2'd2);
        if (20'(h_eff[10:1]) > 20'(hh[19:1]))
            st_fin = 11'(h_eff[10:1] - 10'(hh[19:1]));
        else
            st_fin = '0;
        en_sum = 20'(hh[19:1]) + 20'(h_eff[10:1]);
        en_fin = (en_sum > 20'(h_eff)) ? h_eff : en_sum[10:0];
    end

    // Pixel row results.
    always_comb
    begin
        q_hi    = q[DIV_W-1:8];
        in_span = column_ready_reg && (line_height_reg != '0)
                  && ({1'b0, row_reg} >= span_start_reg) && ({1'b0, row_reg} < span_end_reg);
        if (d_neg_reg)
            pv = in_span && (q_hi == '0);
        else
            pv = in_span && (q_hi < 32'(th_eff));
        ty         = (pv && !d_neg_reg) ? q_hi[9:0] : '0;
        texel_full = 21'(ty * w_eff) + 21'(tex_x_reg);
        texel      = pv ? texel_full[19:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg           <= 11'd512;
            tw_reg           <= 11'd64;
            th_reg           <= 11'd64;
            column_ready_reg <= 1'b0;
            tex_reg          <= '0;
            tex_x_reg        <= '0;
            line_height_reg  <= '0;
            span_start_reg   <= '0;
            span_end_reg     <= '0;
            column_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SCREEN_HEIGHT:  sh_reg <= cfg_data;
                    CFG_TEXTURE_WIDTH:  tw_reg <= cfg_data;
                    CFG_TEXTURE_HEIGHT: th_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.finish && op_reg == OP_SETUP)
            begin
                column_ready_reg <= 1'b1;
                tex_reg          <= tex_fin;
                tex_x_reg        <= tx_fin;
                line_height_reg  <= hh;
                span_start_reg   <= st_fin;
                span_end_reg     <= en_fin;
                column_reg       <= col_in_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= in_op;
            hit_reg    <= in_data[0];
            sxp_reg    <= in_data[1];
            syp_reg    <= in_data[2];
            dir_x_reg  <= in_data[18:3];
            dir_y_reg  <= in_data[34:19];
            px_reg     <= in_data[58:35];
            py_reg     <= in_data[82:59];
            perp_reg   <= in_data[106:83];
            ang_reg    <= in_data[118:107];
            col_in_reg <= in_data[129:119];
            row_reg    <= in_data[139:130];
        end
        if (cmd.prep)
        begin
            cos_reg  <= cos_rom[ang_reg[11 -: COS_IDX_W]];
            prod_reg <= $signed({1'b0, perp_reg}) * d_sel;
            d_reg    <= 30'(signed'({12'b0, row_reg, 8'b0}))
                        - 30'(signed'({12'b0, h_eff, 7'b0}))
                        + 30'(signed'({3'b0, line_height_reg, 7'b0}));
        end
        if (cmd.mult)
        begin
            cp_reg    <= $signed({1'b0, perp_reg}) * cos_reg;
            txp_reg   <= 27'(frac * w_eff);
            num_reg   <= DIV_W'(d_abs * th_eff);
            d_neg_reg <= d_reg[29];
        end
        if (cmd.finish)
        begin
            res_kind_reg <= op_reg;
            if (op_reg == OP_SETUP)
                res_reg <= {2'b0, 10'b0, col_in_reg, 1'b0, 20'b0, 10'b0,
                            en_fin, st_fin, tx_fin, tex_fin};
            else
                res_reg <= {2'b0, row_reg, column_reg, pv, texel, ty,
                            span_end_reg, span_start_reg, tex_x_reg, tex_reg};
        end
        if (cmd.load_out)
        begin
            out_reg      <= res_reg;
            out_kind_reg <= res_kind_reg;
        end
    end

    assign out_data = out_reg;
    assign out_kind = out_kind_reg;

endmodule

// ===== rtl/core/raycast_wall_texture_column.sv =====
// Each item goes through the prep, multiply, divider start, divider wait, finish and
// output states before the next is taken; the 40-step radix-2 divider sets the pace,
// shared by the line height of a setup item and the texture row of a row item.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) restores the default registers and
// clears the column state; no item is in flight afterwards.
`timescale 1ns / 1ps

module raycast_wall_texture_column (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // hit side, x step sign, y step sign, x direction, y direction, viewer x,
    // viewer y, wall distance, angle offset, column, row, zero fill
    input  logic [rwtc_pkg::IN_W-1:0]       s_axis_tdata,
    // opcode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // texture_id, tex_x, draw_start, draw stop, tex_y, texel_index, pixel_valid,
    // out_column, out_row, zero fill
    output logic [rwtc_pkg::OUT_W-1:0]      m_axis_tdata,
    // result_kind
    output logic                            m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rwtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwtc_pkg::CFG_W-1:0]      cfg_data
);
    import rwtc_pkg::*;

    rwtc_cmd_t    cmd;
    rwtc_status_t status;

    assign cfg_ready = 1'b1;

    rwtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rwtc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== rtl/core/rwtc_checker.sv =====
// Port-level checks on the wall texture column mapper, bound to the top level.
`timescale 1ns / 1ps

module rwtc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [rwtc_pkg::OUT_W-1:0]  m_axis_tdata,
    input logic                        m_axis_tuser
);
    import rwtc_pkg::*;

    // One item at a time: the input closes right after an item is taken.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SUMMARY
        |-> m_axis_tdata[64:34] == '0 && m_axis_tdata[85:76] == '0)
        else $error("column summary carries pixel fields");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_PIXEL && !m_axis_tdata[64]
        |-> m_axis_tdata[63:34] == '0)
        else $error("invalid pixel carries texel data");

endmodule

bind raycast_wall_texture_column rwtc_checker u_rwtc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
